/* rtl/assert_macros.svh */
// shared assertion shorthands for the pixel writer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PFW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PFW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pfw_pkg.sv */
package pfw_pkg;

  // largest buffer dimension, larger register values saturate to it
  localparam int MAX_DIMENSION = 2048;

  // fixed field widths
  localparam int CFG_DIM_W = 12;
  localparam int XY_W      = 16;
  localparam int COLOUR_W  = 8;
  localparam int ADDR_W    = 24;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 3;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 3;

  // widths that follow from the largest dimension
  localparam int DIM_W    = $clog2(MAX_DIMENSION + 1);
  localparam int COORD_W  = $clog2(MAX_DIMENSION);
  localparam int STRIDE_W = $clog2(MAX_DIMENSION + 8);
  localparam int PIX_W    = COORD_W + STRIDE_W;
  localparam int CMP_W    = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int SCALE_W  = (PIX_W + 2 > ADDR_W) ? PIX_W + 2 : ADDR_W;

  // luma weights, unsigned 0.16
  localparam int GRAY_ACC_W = 24;
  localparam logic [15:0] GRAY_WR = 16'd13926;
  localparam logic [15:0] GRAY_WG = 16'd46884;
  localparam logic [15:0] GRAY_WB = 16'd4725;

  localparam logic [COLOUR_W-1:0] ALPHA_HALF   = 8'h80;
  localparam logic [COLOUR_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [MASK_W-1:0]   MASK_FULL    = 8'hFF;
  localparam logic [MASK_W-1:0]   MASK_MSB     = 8'h80;

  // reset values of the registers
  localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 12'd320;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 12'd240;

  typedef enum logic [1:0] {
    FMT_MONO   = 2'd0,
    FMT_GRAY   = 2'd1,
    FMT_RGB565 = 2'd2,
    FMT_RGB888 = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    TRANS_OPAQUE = 2'd0,
    TRANS_KEY    = 2'd1,
    TRANS_ALPHA  = 2'd2
  } trans_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT      = 3'd0,
    REG_TRANSPARENT = 3'd1,
    REG_ENDIAN      = 3'd2,
    REG_WIDTH       = 3'd3,
    REG_HEIGHT      = 3'd4
  } reg_idx_t;

  // configuration as seen by the formatting logic
  typedef struct packed {
    logic [1:0]           fmt;
    logic [1:0]           tmode;
    logic                 big_endian;
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
  } cfg_t;

endpackage

/* rtl/pixel_format_writer.sv */
// pixel_format_writer: one framebuffer write request per RGBA pixel
//
// input channel in_valid/in_ready carries pixel_x, pixel_y (signed) and the
// red, green, blue and alpha bytes. output channel out_valid/out_ready
// carries status, byte_address, byte_count, write_data and bit_mask; a pixel
// outside the image gives status 1 and all other fields zero.
// configuration goes through cfg_write/cfg_index/cfg_data: 0 pixel format,
// 1 transparency mode, 2 byte order, 3 width, 4 height. write it only while
// no request is in flight.
// the datapath is three register stages: bounds check and luma weights,
// row multiply and byte packing, address scaling into the output register.
// an accepted request passes through stage 1, stage 2 and the output
// register to out_valid; one request per cycle is taken and delivered
// while out_ready is high. when the receiver holds out_ready low the stages
// fill up behind the output register and in_ready drops once all three are
// occupied; nothing is lost or repeated. reset empties the pipeline and
// loads RGB565, opaque, little endian, 320 x 240.
`include "assert_macros.svh"

module pixel_format_writer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pfw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfw_pkg::CFG_DIM_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pfw_pkg::XY_W-1:0]   pixel_x,
  input  logic signed [pfw_pkg::XY_W-1:0]   pixel_y,
  input  logic [pfw_pkg::COLOUR_W-1:0]      red,
  input  logic [pfw_pkg::COLOUR_W-1:0]      green,
  input  logic [pfw_pkg::COLOUR_W-1:0]      blue,
  input  logic [pfw_pkg::COLOUR_W-1:0]      alpha,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [pfw_pkg::ADDR_W-1:0]        byte_address,
  output logic [pfw_pkg::COUNT_W-1:0]       byte_count,
  output logic [pfw_pkg::DATA_W-1:0]        write_data,
  output logic [pfw_pkg::MASK_W-1:0]        bit_mask
);
  import pfw_pkg::*;

  cfg_t cfg;

  logic en1;
  logic en2;
  logic en3;

  logic [DIM_W-1:0]      w_cl;
  logic [DIM_W-1:0]      h_cl;
  logic [STRIDE_W-1:0]   w_pad;
  logic                  reject_next;
  logic [GRAY_ACC_W-1:0] gray_acc;

  logic                  s1_valid;
  logic                  s1_reject;
  logic [COORD_W-1:0]    s1_ux;
  logic [COORD_W-1:0]    s1_uy;
  logic [STRIDE_W-1:0]   s1_stride;
  logic [COLOUR_W-1:0]   s1_gray;
  logic [COLOUR_W-1:0]   s1_red;
  logic [COLOUR_W-1:0]   s1_green;
  logic [COLOUR_W-1:0]   s1_blue;
  logic [COLOUR_W-1:0]   s1_alpha;

  logic [DATA_W-1:0]     pack_data;
  logic [COUNT_W-1:0]    pack_count;
  logic                  pack_lit;

  logic                  s2_valid;
  logic                  s2_reject;
  logic [PIX_W-1:0]      s2_pix;
  logic [DATA_W-1:0]     s2_data;
  logic [COUNT_W-1:0]    s2_count;
  logic                  s2_lit;

  logic [SCALE_W-1:0]    pix_ext;
  logic [SCALE_W-1:0]    scaled;
  logic [MASK_W-1:0]     mono_bit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt        <= FMT_RGB565;
      cfg.tmode      <= TRANS_OPAQUE;
      cfg.big_endian <= 1'b0;
      cfg.width      <= WIDTH_RESET;
      cfg.height     <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FORMAT:      cfg.fmt        <= cfg_data[1:0];
        REG_TRANSPARENT: cfg.tmode      <= cfg_data[1:0];
        REG_ENDIAN:      cfg.big_endian <= cfg_data[0];
        REG_WIDTH:       cfg.width      <= cfg_data;
        REG_HEIGHT:      cfg.height     <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables, a stage moves when the one after it can take its request
  assign en3      = !out_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // saturated dimensions and padded mono row length
  assign w_cl  = (CMP_W'(cfg.width) > CMP_W'(MAX_DIMENSION)) ?
                 DIM_W'(MAX_DIMENSION) : DIM_W'(cfg.width);
  assign h_cl  = (CMP_W'(cfg.height) > CMP_W'(MAX_DIMENSION)) ?
                 DIM_W'(MAX_DIMENSION) : DIM_W'(cfg.height);
  assign w_pad = (STRIDE_W'(w_cl) + STRIDE_W'(7)) & ~STRIDE_W'(7);

  // bounds check against the image
  assign reject_next = pixel_x[XY_W-1] || pixel_y[XY_W-1] ||
                       ($unsigned(pixel_x) >= XY_W'(w_cl)) ||
                       ($unsigned(pixel_y) >= XY_W'(h_cl));

  // weighted luma sum, truncated to the integer part
  assign gray_acc = GRAY_ACC_W'(GRAY_WR) * GRAY_ACC_W'(red)
                  + GRAY_ACC_W'(GRAY_WG) * GRAY_ACC_W'(green)
                  + GRAY_ACC_W'(GRAY_WB) * GRAY_ACC_W'(blue);

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_reject <= reject_next;
      s1_ux     <= pixel_x[COORD_W-1:0];
      s1_uy     <= pixel_y[COORD_W-1:0];
      s1_stride <= (cfg.fmt == FMT_MONO) ? w_pad : STRIDE_W'(w_cl);
      s1_gray   <= gray_acc[GRAY_ACC_W-1 -: COLOUR_W];
      s1_red    <= red;
      s1_green  <= green;
      s1_blue   <= blue;
      s1_alpha  <= alpha;
    end
  end

  // byte packing for the selected format
  pfw_pack u_pack (
    .cfg   (cfg),
    .red   (s1_red),
    .green (s1_green),
    .blue  (s1_blue),
    .alpha (s1_alpha),
    .gray  (s1_gray),
    .data  (pack_data),
    .count (pack_count),
    .lit   (pack_lit)
  );

  // stage 2: pixel index within the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_reject <= s1_reject;
      s2_pix    <= PIX_W'(PIX_W'(s1_uy) * PIX_W'(s1_stride)) + PIX_W'(s1_ux);
      s2_data   <= pack_data;
      s2_count  <= pack_count;
      s2_lit    <= pack_lit;
    end
  end

  // byte address scaling, count equals bytes per pixel
  assign pix_ext = SCALE_W'(s2_pix);

  always_comb begin
    case (s2_count)
      3'd2:    scaled = pix_ext << 1;
      3'd3:    scaled = (pix_ext << 1) + pix_ext;
      3'd4:    scaled = pix_ext << 2;
      default: scaled = pix_ext;
    endcase
  end

  assign mono_bit = MASK_MSB >> s2_pix[2:0];

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      if (s2_reject) begin
        status       <= 1'b1;
        byte_address <= '0;
        byte_count   <= '0;
        write_data   <= '0;
        bit_mask     <= '0;
      end else if (cfg.fmt == FMT_MONO) begin
        status       <= 1'b0;
        byte_address <= ADDR_W'(pix_ext >> 3);
        byte_count   <= 3'd1;
        write_data   <= s2_lit ? DATA_W'(mono_bit) : '0;
        bit_mask     <= mono_bit;
      end else begin
        status       <= 1'b0;
        byte_address <= scaled[ADDR_W-1:0];
        byte_count   <= s2_count;
        write_data   <= s2_data;
        bit_mask     <= MASK_FULL;
      end
    end
  end

  // checks
  `PFW_ASSERT_IMP(a_reject_zero, out_valid && status,
    byte_count == '0 && bit_mask == '0 && write_data == '0,
    "rejected request carries a write")
  `PFW_ASSERT_IMP(a_count_range, out_valid && !status,
    byte_count != '0 && byte_count <= 3'd4,
    "issued write has a bad byte count")
  `PFW_ASSERT_IMP(a_mono_mask, out_valid && !status && cfg.fmt == FMT_MONO,
    $onehot(bit_mask) && byte_count == 3'd1,
    "mono write must touch exactly one bit")
  `PFW_ASSERT_NXT(a_accept_fill, in_valid && in_ready,
    s1_valid,
    "accepted pixel did not enter the first stage")

endmodule

/* rtl/pfw_pack.sv */
module pfw_pack (
  input  pfw_pkg::cfg_t                   cfg,
  input  logic [pfw_pkg::COLOUR_W-1:0]    red,
  input  logic [pfw_pkg::COLOUR_W-1:0]    green,
  input  logic [pfw_pkg::COLOUR_W-1:0]    blue,
  input  logic [pfw_pkg::COLOUR_W-1:0]    alpha,
  input  logic [pfw_pkg::COLOUR_W-1:0]    gray,
  output logic [pfw_pkg::DATA_W-1:0]      data,
  output logic [pfw_pkg::COUNT_W-1:0]     count,
  output logic                            lit
);
  import pfw_pkg::*;

  logic                is_key;
  logic                is_alpha;
  logic                see_through;
  logic [COLOUR_W-1:0] lum;
  logic [COLOUR_W-1:0] gray_m;
  logic [COLOUR_W-1:0] r_m;
  logic [COLOUR_W-1:0] g_m;
  logic [COLOUR_W-1:0] b_m;
  logic [15:0]         c565;
  logic [15:0]         c565_ord;

  // reserved mode code falls through as opaque
  assign is_key      = (cfg.tmode == TRANS_KEY);
  assign is_alpha    = (cfg.tmode == TRANS_ALPHA);
  assign see_through = (alpha < ALPHA_HALF);

  // mono luma approximation, lit on bit 7
  assign lum = {2'b00, red[7:2]} + {1'b0, green[7:1]} + {2'b00, blue[7:2]};
  assign lit = lum[7] && !((is_key || is_alpha) && see_through);

  // grayscale transparency handling
  always_comb begin
    gray_m = gray;
    if (is_key) begin
      if (gray == 8'd1) gray_m = '0;
      if (see_through) gray_m = 8'd1;
    end else if (is_alpha) begin
      if (alpha != ALPHA_OPAQUE) gray_m = alpha;
    end
  end

  // chroma key remapping for the colour formats
  always_comb begin
    r_m = red;
    g_m = green;
    b_m = blue;
    if (is_key) begin
      if (green == 8'd1 && red == '0 && blue == '0) g_m = '0;
      if (see_through) begin
        r_m = '0;
        b_m = '0;
        g_m = (cfg.fmt == FMT_RGB565) ? 8'd4 : 8'd1;
      end
    end
  end

  assign c565     = {r_m[7:3], g_m[7:2], b_m[7:3]};
  assign c565_ord = cfg.big_endian ? {c565[7:0], c565[15:8]} : c565;

  // byte packing, first byte in the low bits
  always_comb begin
    data  = '0;
    count = 3'd1;
    unique case (cfg.fmt)
      FMT_MONO: begin
        data  = '0;
        count = 3'd1;
      end
      FMT_GRAY: begin
        data  = {24'd0, gray_m};
        count = 3'd1;
      end
      FMT_RGB565: begin
        data  = is_alpha ? {8'd0, alpha, c565_ord} : {16'd0, c565_ord};
        count = is_alpha ? 3'd3 : 3'd2;
      end
      default: begin
        data  = {(is_alpha ? alpha : 8'd0), b_m, g_m, r_m};
        count = is_alpha ? 3'd4 : 3'd3;
      end
    endcase
  end

endmodule
